// File: hdl/ampf_pkg.sv
package ampf_pkg;

  localparam logic [7:0] REPORT_MAX = 8'd255;
  localparam logic [7:0] MFR_TYPE   = 8'hFF;
  localparam logic [7:0] MFR_HDR_LEN = 8'd3;
  localparam logic [7:0] MFR_MIN_FIELD = 8'd4;

  localparam logic [15:0] COMPANY_RESET = 16'hFFFF;
  localparam logic [7:0]  MAGIC_RESET   = 8'd0;
  localparam logic [7:0]  MIN_LEN_RESET = 8'd0;
  localparam logic [4:0]  MAX_LEN_RESET = 5'd28;

  localparam logic [7:0] CFG_COMPANY_ID    = 8'd0;
  localparam logic [7:0] CFG_MAGIC_BYTE    = 8'd1;
  localparam logic [7:0] CFG_MIN_FRAME_LEN = 8'd2;
  localparam logic [7:0] CFG_MAX_FRAME_LEN = 8'd3;

  typedef enum logic [2:0] {
    PH_LEN   = 3'd0,
    PH_TYPE  = 3'd1,
    PH_CO_LO = 3'd2,
    PH_CO_HI = 3'd3,
    PH_MAGIC = 3'd4,
    PH_DATA  = 3'd5,
    PH_SKIP  = 3'd6
  } phase_t;

  typedef struct packed {
    logic [15:0] company_id;
    logic [7:0]  magic_byte;
    logic [7:0]  min_frame_len;
    logic [4:0]  max_frame_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [4:0] frame_length;
    logic       frame_last;
  } res_t;

endpackage

// File: hdl/ampf_parser.sv
module ampf_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        ad_byte,
  input  logic [7:0]        report_length,
  input  logic              report_start,
  input  ampf_pkg::cfg_t    cfg,
  output logic              emit,
  output ampf_pkg::res_t    res
);
  import ampf_pkg::*;

  logic [7:0] byte_index_r, byte_index_nxt;
  logic [7:0] field_begin_r, field_begin_nxt;
  logic [7:0] field_len_r, field_len_nxt;
  phase_t     phase_r, phase_nxt;
  logic       accepted_r, accepted_nxt;
  logic       stopped_r, stopped_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r  <= '0;
      field_begin_r <= '0;
      field_len_r   <= '0;
      phase_r       <= PH_LEN;
      accepted_r    <= 1'b0;
      stopped_r     <= 1'b0;
    end else if (step) begin
      byte_index_r  <= byte_index_nxt;
      field_begin_r <= field_begin_nxt;
      field_len_r   <= field_len_nxt;
      phase_r       <= phase_nxt;
      accepted_r    <= accepted_nxt;
      stopped_r     <= stopped_nxt;
    end
  end

  logic [7:0] n;
  logic [7:0] idx;
  phase_t     phase;
  logic [7:0] plen;
  logic [8:0] field_end;
  logic       at_end;

  always_comb begin
    n    = (report_length > REPORT_MAX) ? REPORT_MAX : report_length;
    idx  = report_start ? 8'd0 : byte_index_r;
    phase = report_start ? PH_LEN : phase_r;

    byte_index_nxt  = idx;
    field_begin_nxt = report_start ? 8'd0 : field_begin_r;
    field_len_nxt   = report_start ? 8'd0 : field_len_r;
    accepted_nxt    = report_start ? 1'b0 : accepted_r;
    stopped_nxt     = report_start ? 1'b0 : stopped_r;
    phase_nxt       = phase;
    plen            = '0;
    field_end       = '0;
    at_end          = 1'b0;
    emit            = 1'b0;
    res             = '0;

    if (!stopped_nxt) begin
      case (phase)
        PH_LEN: begin
          if ({1'b0, idx} + 9'd1 >= {1'b0, n} || ad_byte == 8'd0 ||
              {2'b00, idx} + 10'd1 + {2'b00, ad_byte} > {2'b00, n}) begin
            stopped_nxt = 1'b1;
          end else begin
            field_begin_nxt = idx;
            field_len_nxt   = ad_byte;
            accepted_nxt    = 1'b0;
            phase_nxt       = PH_TYPE;
          end
        end
        PH_TYPE: begin
          plen = field_len_nxt - MFR_HDR_LEN;
          accepted_nxt = ad_byte == MFR_TYPE && field_len_nxt >= MFR_MIN_FIELD &&
                         plen >= cfg.min_frame_len &&
                         plen <= {3'b000, cfg.max_frame_len};
          phase_nxt = accepted_nxt ? PH_CO_LO : PH_SKIP;
        end
        PH_CO_LO: begin
          accepted_nxt = accepted_nxt && ad_byte == cfg.company_id[7:0];
          phase_nxt = accepted_nxt ? PH_CO_HI : PH_SKIP;
        end
        PH_CO_HI: begin
          accepted_nxt = accepted_nxt && ad_byte == cfg.company_id[15:8];
          phase_nxt = accepted_nxt ? PH_MAGIC : PH_SKIP;
        end
        PH_MAGIC: begin
          accepted_nxt = accepted_nxt && ad_byte == cfg.magic_byte;
          phase_nxt = accepted_nxt ? PH_DATA : PH_SKIP;
        end
        PH_DATA: begin
          phase_nxt = PH_DATA;
        end
        default: begin
          phase_nxt = PH_SKIP;
        end
      endcase

      if (!stopped_nxt) begin
        field_end = {1'b0, field_begin_nxt} + {1'b0, field_len_nxt};
        at_end    = {1'b0, idx} == field_end;
        if (accepted_nxt && (phase == PH_MAGIC || phase == PH_DATA)) begin
          emit             = 1'b1;
          res.frame_byte   = ad_byte;
          res.frame_length = 5'(field_len_nxt - MFR_HDR_LEN);
          res.frame_last   = at_end;
        end
        if (at_end) begin
          phase_nxt    = PH_LEN;
          accepted_nxt = 1'b0;
        end
        byte_index_nxt = idx + 8'd1;
      end
    end
  end

endmodule

// File: hdl/adv_manufacturer_pdu_filter.sv
// Channel   Ports                                       Direction
// in        in_valid in_stall in_ad_byte in_report_*    bytes of one report
// out       out_valid out_stall out_frame_*             frame bytes, one per request
// cfg       cfg_valid cfg_ready cfg_index cfg_data      register writes
//
// One byte per cycle sustained while the output is not stalled.
// The input register feeds the field parser, whose result lands in the output register.
// A held result only stalls the input once the input register is also occupied.
// Synchronous active-low reset clears parser state and loads register defaults.
module adv_manufacturer_pdu_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ad_byte,
  input  logic [7:0]  in_report_length,
  input  logic        in_report_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame_byte,
  output logic [4:0]  out_frame_length,
  output logic        out_frame_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ampf_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.company_id    <= COMPANY_RESET;
      cfg_r.magic_byte    <= MAGIC_RESET;
      cfg_r.min_frame_len <= MIN_LEN_RESET;
      cfg_r.max_frame_len <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COMPANY_ID:    cfg_r.company_id    <= cfg_data;
        CFG_MAGIC_BYTE:    cfg_r.magic_byte    <= cfg_data[7:0];
        CFG_MIN_FRAME_LEN: cfg_r.min_frame_len <= cfg_data[7:0];
        CFG_MAX_FRAME_LEN: cfg_r.max_frame_len <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic [7:0] s1_len_r;
  logic       s1_start_r;
  logic       out_valid_r;
  logic       advance;
  logic       in_take;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_ad_byte;
      s1_len_r   <= in_report_length;
      s1_start_r <= in_report_start;
    end
  end

  logic emit;
  res_t res;

  ampf_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .ad_byte       (s1_byte_r),
    .report_length (s1_len_r),
    .report_start  (s1_start_r),
    .cfg           (cfg_r),
    .emit          (emit),
    .res           (res)
  );

  res_t out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_byte   = out_res_r.frame_byte;
  assign out_frame_length = out_res_r.frame_length;
  assign out_frame_last   = out_res_r.frame_last;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled while a stage was free");

  a_frame_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_length != 5'd0)
    else $error("frame emitted with zero length");

  a_held_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && !advance |=> out_valid_r && $stable(out_res_r))
    else $error("held result lost without a new stage advance");

endmodule
